// File: src/rsnh_pkg.sv
// Package for the ray/sphere nearest-hit picker.
// Holds request/result structs, config indices, controller states and command/status types.
// No dependencies.
package rsnh_pkg;

    typedef struct packed {
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic signed [31:0] center_z;
        logic        [30:0] bounds_radius;
        logic signed [31:0] scale_x;
        logic signed [31:0] scale_y;
        logic signed [31:0] scale_z;
        logic        [15:0] object_id;
        logic               eligible;
        logic               last_in_list;
    } t_req;

    typedef struct packed {
        logic        hit_found;
        logic [15:0] nearest_object;
        logic [30:0] nearest_distance;
    } t_rsp;

    localparam logic [2:0] CFG_ORG_X = 3'd0;
    localparam logic [2:0] CFG_ORG_Y = 3'd1;
    localparam logic [2:0] CFG_ORG_Z = 3'd2;
    localparam logic [2:0] CFG_DIR_X = 3'd3;
    localparam logic [2:0] CFG_DIR_Y = 3'd4;
    localparam logic [2:0] CFG_DIR_Z = 3'd5;

    typedef enum logic [3:0] {
        ST_IDLE, ST_PREP, ST_MUL_A, ST_SUM_A, ST_MUL_B, ST_SUM_B,
        ST_MUL_BB, ST_DISC, ST_SQRT, ST_ROOT, ST_UPDATE, ST_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic prep;
        logic mul_a;
        logic sum_a;
        logic mul_b;
        logic sum_b;
        logic mul_bb;
        logic disc;
        logic sqrt_step;
        logic root;
        logic update;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic eligible;
        logic last;
        logic reject_cb;
        logic reject_disc;
        logic sqrt_done;
    } t_sts;

endpackage

// File: src/ray_sphere_nearest_hit.sv
// Top level of the ray/sphere nearest-hit picker.
// Depends on rsnh_pkg, rsnh_ctrl and rsnh_dp.
//
// Usage: write the ray origin and direction over the config channel
// (index 0..5: origin x/y/z, direction x/y/z) while idle. Then send sphere
// requests on i_req_*. Each request is taken when i_req_valid is high and
// o_req_stall is low; the block takes one request at a time.
// A request that is not eligible skips the datapath steps. An eligible one
// runs the multiply and sum steps and, unless rejected first, the square root
// in the one-bit-pair-per-cycle root unit over the 48-bit radicand (at Q16.16).
// A request flagged last adds one result on o_rsp_*, held in
// an output register until taken. New requests are still taken while that
// result waits; only the next result holds the block, with no new request
// taken, until i_rsp_stall lets the waiting one go. After the result the
// running best hit clears. Reset (synchronous, active low) restores the
// default ray (origin 0, direction +z) and clears the best hit.
module ray_sphere_nearest_hit #(
    parameter int FRAC_BITS = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    output logic            o_req_stall,
    input  rsnh_pkg::t_req  i_req_data,
    output logic            o_rsp_valid,
    input  logic            i_rsp_stall,
    output rsnh_pkg::t_rsp  o_rsp_data,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic [2:0]      i_cfg_index,
    input  logic [31:0]     i_cfg_data
);

    logic signed [31:0] r_org_x, r_org_y, r_org_z;
    logic signed [17:0] r_dir_x, r_dir_y, r_dir_z;
    logic               r_rsp_valid;
    rsnh_pkg::t_rsp     r_rsp;
    rsnh_pkg::t_cmd     cmd;
    rsnh_pkg::t_sts     sts;
    rsnh_pkg::t_rsp     dp_rsp;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org_x <= '0;
            r_org_y <= '0;
            r_org_z <= '0;
            r_dir_x <= '0;
            r_dir_y <= '0;
            r_dir_z <= 18'sd65536;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                rsnh_pkg::CFG_ORG_X: r_org_x <= i_cfg_data;
                rsnh_pkg::CFG_ORG_Y: r_org_y <= i_cfg_data;
                rsnh_pkg::CFG_ORG_Z: r_org_z <= i_cfg_data;
                rsnh_pkg::CFG_DIR_X: r_dir_x <= i_cfg_data[17:0];
                rsnh_pkg::CFG_DIR_Y: r_dir_y <= i_cfg_data[17:0];
                rsnh_pkg::CFG_DIR_Z: r_dir_z <= i_cfg_data[17:0];
                default: ;
            endcase
        end
    end

    rsnh_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_stall (o_req_stall),
        .i_rsp_busy  (r_rsp_valid && i_rsp_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    rsnh_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req_data),
        .i_cmd   (cmd),
        .i_org_x (r_org_x),
        .i_org_y (r_org_y),
        .i_org_z (r_org_z),
        .i_dir_x (r_dir_x),
        .i_dir_y (r_dir_y),
        .i_dir_z (r_dir_z),
        .o_sts   (sts),
        .o_rsp   (dp_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (cmd.emit) begin
            r_rsp_valid <= 1'b1;
        end else if (!i_rsp_stall) begin
            r_rsp_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd.emit) r_rsp <= dp_rsp;
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp_data  = r_rsp;

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> !(r_rsp_valid && i_rsp_stall))
        else $error("result overwritten while stalled");
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(cmd))
        else $error("more than one datapath command");
    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |=> o_rsp_valid)
        else $error("result not presented");
    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.sqrt_step |-> o_req_stall)
        else $error("request taken during root");

endmodule

// File: src/rsnh_ctrl.sv
// Controller for the nearest-hit picker: sequences one request through the datapath.
// Depends on rsnh_pkg.
module rsnh_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    output logic           o_req_stall,
    input  logic           i_rsp_busy,
    input  rsnh_pkg::t_sts i_sts,
    output rsnh_pkg::t_cmd o_cmd
);

    rsnh_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rsnh_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            rsnh_pkg::ST_IDLE:   if (i_req_valid) n_state = rsnh_pkg::ST_PREP;
            rsnh_pkg::ST_PREP: begin
                if (i_sts.eligible) n_state = rsnh_pkg::ST_MUL_A;
                else if (i_sts.last) n_state = rsnh_pkg::ST_OUT;
                else n_state = rsnh_pkg::ST_IDLE;
            end
            rsnh_pkg::ST_MUL_A:  n_state = rsnh_pkg::ST_SUM_A;
            rsnh_pkg::ST_SUM_A:  n_state = rsnh_pkg::ST_MUL_B;
            rsnh_pkg::ST_MUL_B:  n_state = rsnh_pkg::ST_SUM_B;
            rsnh_pkg::ST_SUM_B:  n_state = rsnh_pkg::ST_MUL_BB;
            rsnh_pkg::ST_MUL_BB: n_state = rsnh_pkg::ST_DISC;
            rsnh_pkg::ST_DISC: begin
                if (i_sts.reject_cb || i_sts.reject_disc) begin
                    n_state = i_sts.last ? rsnh_pkg::ST_OUT : rsnh_pkg::ST_IDLE;
                end else begin
                    n_state = rsnh_pkg::ST_SQRT;
                end
            end
            rsnh_pkg::ST_SQRT:   if (i_sts.sqrt_done) n_state = rsnh_pkg::ST_ROOT;
            rsnh_pkg::ST_ROOT:   n_state = rsnh_pkg::ST_UPDATE;
            rsnh_pkg::ST_UPDATE: n_state = i_sts.last ? rsnh_pkg::ST_OUT : rsnh_pkg::ST_IDLE;
            rsnh_pkg::ST_OUT:    if (!i_rsp_busy) n_state = rsnh_pkg::ST_IDLE;
            default:             n_state = rsnh_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_req_stall = 1'b1;
        case (r_state)
            rsnh_pkg::ST_IDLE: begin
                o_req_stall = 1'b0;
                o_cmd.load  = i_req_valid;
            end
            rsnh_pkg::ST_PREP:   o_cmd.prep = 1'b1;
            rsnh_pkg::ST_MUL_A:  o_cmd.mul_a = 1'b1;
            rsnh_pkg::ST_SUM_A:  o_cmd.sum_a = 1'b1;
            rsnh_pkg::ST_MUL_B:  o_cmd.mul_b = 1'b1;
            rsnh_pkg::ST_SUM_B:  o_cmd.sum_b = 1'b1;
            rsnh_pkg::ST_MUL_BB: o_cmd.mul_bb = 1'b1;
            rsnh_pkg::ST_DISC:   o_cmd.disc = 1'b1;
            rsnh_pkg::ST_SQRT:   o_cmd.sqrt_step = 1'b1;
            rsnh_pkg::ST_ROOT:   o_cmd.root = 1'b1;
            rsnh_pkg::ST_UPDATE: o_cmd.update = 1'b1;
            rsnh_pkg::ST_OUT:    o_cmd.emit = !i_rsp_busy;
            default:             o_cmd = '0;
        endcase
    end

endmodule

// File: src/rsnh_dp.sv
// Datapath for the nearest-hit picker: multiplies, sums, iterative root, best-hit state.
// Depends on rsnh_pkg.
module rsnh_dp #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rsnh_pkg::t_req     i_req,
    input  rsnh_pkg::t_cmd     i_cmd,
    input  logic signed [31:0] i_org_x,
    input  logic signed [31:0] i_org_y,
    input  logic signed [31:0] i_org_z,
    input  logic signed [17:0] i_dir_x,
    input  logic signed [17:0] i_dir_y,
    input  logic signed [17:0] i_dir_z,
    output rsnh_pkg::t_sts     o_sts,
    output rsnh_pkg::t_rsp     o_rsp
);

    localparam logic [31:0] FLOOR_RAW = 32'(((64'd1 << FRAC_BITS) + 64'd500) / 64'd1000);
    localparam logic [31:0] SCALE_FLOOR = (FLOOR_RAW == 32'd0) ? 32'd1 : FLOOR_RAW;
    localparam int          SQ_W = 32 + FRAC_BITS;
    localparam int          SQ_STEPS = (SQ_W + 1) / 2;
    localparam int          CNT_W = $clog2(SQ_STEPS + 1);
    localparam logic signed [63:0] MAX32 = 64'sd2147483647;
    localparam logic signed [63:0] MIN32 = -64'sd2147483648;

    function automatic logic signed [31:0] sat(input logic signed [63:0] x);
        if (x > MAX32) return 32'sh7fffffff;
        if (x < MIN32) return 32'sh80000000;
        return x[31:0];
    endfunction

    function automatic logic [31:0] uabs(input logic signed [31:0] x);
        return x[31] ? 32'(-x) : 32'(x);
    endfunction

    rsnh_pkg::t_req     r_req;
    logic signed [31:0] r_mx, r_my, r_mz, r_r, r_b, r_c;
    logic [31:0]        r_ms;
    logic signed [63:0] r_p0, r_p1, r_p2, r_p3;
    logic [SQ_W-1:0]    r_sq_v, r_sq_res, r_sq_bit;
    logic [CNT_W-1:0]   r_sq_cnt;
    logic signed [33:0] r_t;
    logic [31:0]        r_best_dist;
    logic [15:0]        r_best_obj;
    logic               r_any_hit;
    logic               r_reject_cb;

    logic [31:0]        ax, ay, az, ms_max;
    logic signed [63:0] sum_a, sum_b, disc_w;
    logic signed [31:0] disc;
    logic [SQ_W-1:0]    sq_trial;
    logic signed [33:0] t_near, t_far;

    always_comb begin
        ax = uabs(r_req.scale_x);
        ay = uabs(r_req.scale_y);
        az = uabs(r_req.scale_z);
        ms_max = ax;
        if (ay > ms_max) ms_max = ay;
        if (az > ms_max) ms_max = az;
        if (ms_max < SCALE_FLOOR) ms_max = SCALE_FLOOR;
        sum_a  = (r_p0 + r_p1 + r_p2) >>> FRAC_BITS;
        sum_b  = (r_p0 >>> FRAC_BITS) + (r_p1 >>> FRAC_BITS) + (r_p2 >>> FRAC_BITS)
                 - (r_p3 >>> FRAC_BITS);
        disc_w = 64'(sat(r_p0 >>> FRAC_BITS)) - 64'(r_c);
        disc   = sat(disc_w);
        sq_trial = r_sq_res + r_sq_bit;
        t_near = -34'(r_b) - 34'($signed({1'b0, r_sq_res[32:0]}));
        t_far  = -34'(r_b) + 34'($signed({1'b0, r_sq_res[32:0]}));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_req <= i_req;
        if (i_cmd.prep) begin
            r_mx <= sat(64'(i_org_x) - 64'(r_req.center_x));
            r_my <= sat(64'(i_org_y) - 64'(r_req.center_y));
            r_mz <= sat(64'(i_org_z) - 64'(r_req.center_z));
            r_ms <= ms_max;
        end
        if (i_cmd.mul_a) begin
            r_p0 <= r_mx * 64'(i_dir_x);
            r_p1 <= r_my * 64'(i_dir_y);
            r_p2 <= r_mz * 64'(i_dir_z);
            r_p3 <= $signed({33'd0, r_req.bounds_radius}) * $signed({32'd0, r_ms});
        end
        if (i_cmd.sum_a) begin
            r_b <= sat(sum_a);
            r_r <= sat(r_p3 >>> FRAC_BITS);
        end
        if (i_cmd.mul_b) begin
            r_p0 <= r_mx * r_mx;
            r_p1 <= r_my * r_my;
            r_p2 <= r_mz * r_mz;
            r_p3 <= r_r * r_r;
        end
        if (i_cmd.sum_b) r_c <= sat(sum_b);
        if (i_cmd.mul_bb) begin
            r_p0 <= r_b * r_b;
            r_reject_cb <= (r_c > 0) && (r_b > 0);
        end
        if (i_cmd.disc) begin
            r_sq_v   <= SQ_W'({disc[30:0], {FRAC_BITS{1'b0}}});
            r_sq_res <= '0;
            r_sq_bit <= SQ_W'(1) << (2 * SQ_STEPS - 2);
            r_sq_cnt <= '0;
        end
        if (i_cmd.sqrt_step) begin
            if (r_sq_v >= sq_trial) begin
                r_sq_v   <= r_sq_v - sq_trial;
                r_sq_res <= (r_sq_res >> 1) + r_sq_bit;
            end else begin
                r_sq_res <= r_sq_res >> 1;
            end
            r_sq_bit <= r_sq_bit >> 2;
            r_sq_cnt <= r_sq_cnt + 1'b1;
        end
        if (i_cmd.root) r_t <= t_near[33] ? t_far : t_near;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_dist <= '1;
            r_best_obj  <= '0;
            r_any_hit   <= 1'b0;
        end else if (i_cmd.emit) begin
            r_best_dist <= '1;
            r_best_obj  <= '0;
            r_any_hit   <= 1'b0;
        end else if (i_cmd.update && !r_t[33]) begin
            if ((|r_t[32:31] ? 32'h7fffffff : 32'(r_t[30:0])) < r_best_dist) begin
                r_best_dist <= |r_t[32:31] ? 32'h7fffffff : 32'(r_t[30:0]);
                r_best_obj  <= r_req.object_id;
                r_any_hit   <= 1'b1;
            end
        end
    end

    always_comb begin
        o_sts.eligible    = r_req.eligible;
        o_sts.last        = r_req.last_in_list;
        o_sts.reject_cb   = r_reject_cb;
        o_sts.reject_disc = disc[31];
        o_sts.sqrt_done   = (r_sq_cnt == CNT_W'(SQ_STEPS - 1)) && i_cmd.sqrt_step;
        o_rsp.hit_found        = r_any_hit;
        o_rsp.nearest_object   = r_any_hit ? r_best_obj : 16'd0;
        o_rsp.nearest_distance = r_any_hit ? r_best_dist[30:0] : 31'd0;
    end

endmodule
